/* hw/rtl/frwm_pkg.sv */
package frwm_pkg;

   localparam int DataWidth     = 32;
   localparam int WindowSeconds = 5;
   localparam int FillCount     = 70;
   localparam int SlotWidth     = (WindowSeconds > 1) ? $clog2(WindowSeconds) : 1;
   localparam int SumWidth      = DataWidth + $clog2(WindowSeconds);
   localparam int DivWidth      = SumWidth;
   localparam int CountWidth    = $clog2(DivWidth + 1);

   typedef struct packed {
      logic                 start;
      logic [DivWidth-1:0]  dividend;
      logic [DataWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef struct packed {
      logic                 write;
      logic [SlotWidth-1:0] slot;
      logic [DataWidth-1:0] data;
      logic                 sum_start;
   } ring_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ring_sts_type;

endpackage

/* hw/rtl/frwm_req_if.sv */
interface frwm_req_if;
   logic                           valid;
   logic                           ready;
   logic [frwm_pkg::DataWidth-1:0] seconds_now;

   modport source (output valid, output seconds_now, input ready);
   modport sink (input valid, input seconds_now, output ready);
endinterface

/* hw/rtl/frwm_rsp_if.sv */
interface frwm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [frwm_pkg::DataWidth-1:0] window_average;
   logic [frwm_pkg::DataWidth-1:0] overall_rate;
   logic [frwm_pkg::DataWidth-1:0] last_second_frames;
   logic [frwm_pkg::DataWidth-1:0] frame_number;

   modport source (output valid, output window_average, output overall_rate,
                   output last_second_frames, output frame_number, input ready);
   modport sink (input valid, input window_average, input overall_rate,
                 input last_second_frames, input frame_number, output ready);
endinterface

/* hw/rtl/frwm_divider.sv */
module frwm_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  frwm_pkg::div_req_type          div_req,
   output frwm_pkg::div_sts_type          div_sts,
   output logic [frwm_pkg::DivWidth-1:0]  quotient
);

   logic [frwm_pkg::DataWidth-1:0]  rem_ff, rem_in;
   logic [frwm_pkg::DivWidth-1:0]   quo_ff, quo_in;
   logic [frwm_pkg::DataWidth-1:0]  divisor_ff, divisor_in;
   logic [frwm_pkg::CountWidth-1:0] count_ff, count_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [frwm_pkg::DataWidth:0]    shifted;
   logic [frwm_pkg::DataWidth:0]    diff;
   logic                            fits;

   // one restoring step: bring down the next dividend bit
   always_comb begin
      shifted = {rem_ff, quo_ff[frwm_pkg::DivWidth-1]};
      diff    = shifted - {1'b0, divisor_ff};
      fits    = shifted >= {1'b0, divisor_ff};
   end

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
         count_in   = frwm_pkg::CountWidth'(frwm_pkg::DivWidth);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[frwm_pkg::DataWidth-1:0] : shifted[frwm_pkg::DataWidth-1:0];
         quo_in   = {quo_ff[frwm_pkg::DivWidth-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == frwm_pkg::CountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign quotient     = quo_ff;

endmodule

/* hw/rtl/frwm_ring.sv */
module frwm_ring (
   input  logic                          clock,
   input  logic                          reset,
   input  frwm_pkg::ring_ctl_type        ring_ctl,
   output frwm_pkg::ring_sts_type        ring_sts,
   output logic [frwm_pkg::SumWidth-1:0] ring_sum
);

   logic [frwm_pkg::DataWidth-1:0] counts_ff [frwm_pkg::WindowSeconds];
   logic [frwm_pkg::SumWidth-1:0]  acc_ff, acc_in;
   logic [frwm_pkg::SlotWidth-1:0] idx_ff, idx_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < frwm_pkg::WindowSeconds; k++) begin
            counts_ff[k] <= frwm_pkg::DataWidth'(frwm_pkg::FillCount);
         end
      end else if (ring_ctl.write) begin
         counts_ff[ring_ctl.slot] <= ring_ctl.data;
      end
   end

   // walk the ring one entry a cycle through a single adder
   always_comb begin
      acc_in  = acc_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ring_ctl.sum_start) begin
         acc_in  = '0;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + frwm_pkg::SumWidth'(counts_ff[idx_ff]);
         idx_in = idx_ff + 1'b1;
         if (idx_ff == frwm_pkg::SlotWidth'(frwm_pkg::WindowSeconds - 1)) begin
            idx_in  = '0;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      idx_ff <= idx_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ring_sts.busy = busy_ff;
   assign ring_sts.done = done_ff;
   assign ring_sum      = acc_ff;

endmodule

/* hw/rtl/frame_rate_window_meter.sv */
// Frame rate meter: every request marks one finished frame and carries the elapsed whole
// seconds, and yields one response with the window average, overall rate, frames of the
// last finished second and the running frame number. The block handles one request at a
// time and drops ready until its response is registered; the response register lets the
// next request in while the result still waits. A request in the same second as the one
// before goes from the check straight to the response. A request that opens a new second
// writes its slot, then waits for the ring sum and the divider: the ring is summed one
// entry a cycle through one adder, and a single restoring divider, one quotient bit a
// cycle over 32 + clog2(WINDOW_SECONDS) bits, serves first the window average and then,
// for a nonzero second, the overall rate. After reset the ring holds 70 per slot.
module frame_rate_window_meter (
   input logic        clock,
   input logic        reset,
   frwm_req_if.sink   req_bus,
   frwm_rsp_if.source rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUM_WAIT,
      ST_AVG_WAIT,
      ST_ALL_WAIT,
      ST_DONE
   } state_type;

   localparam int DW = frwm_pkg::DataWidth;

   state_type                      state_ff, state_in;
   logic [DW-1:0]                  now_ff, now_in;
   logic [DW-1:0]                  frame_total_ff, frame_total_in;
   logic [DW-1:0]                  at_last_ff, at_last_in;
   logic [DW-1:0]                  last_seen_ff, last_seen_in;
   logic [DW-1:0]                  recent_ff, recent_in;
   logic [frwm_pkg::SlotWidth-1:0] slot_ff, slot_in;
   logic [DW-1:0]                  average_ff, average_in;
   logic [DW-1:0]                  overall_ff, overall_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                  out_avg_ff, out_avg_in;
   logic [DW-1:0]                  out_all_ff, out_all_in;
   logic [DW-1:0]                  out_recent_ff, out_recent_in;
   logic [DW-1:0]                  out_frame_ff, out_frame_in;

   frwm_pkg::div_req_type          div_req;
   frwm_pkg::div_sts_type          div_sts;
   logic [frwm_pkg::DivWidth-1:0]  quotient;
   frwm_pkg::ring_ctl_type         ring_ctl;
   frwm_pkg::ring_sts_type         ring_sts;
   logic [frwm_pkg::SumWidth-1:0]  ring_sum;

   frwm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_sts  (div_sts),
      .quotient (quotient)
   );

   frwm_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ring_ctl (ring_ctl),
      .ring_sts (ring_sts),
      .ring_sum (ring_sum)
   );

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      frame_total_in = frame_total_ff;
      at_last_in     = at_last_ff;
      last_seen_in   = last_seen_ff;
      recent_in      = recent_ff;
      slot_in        = slot_ff;
      average_in     = average_ff;
      overall_in     = overall_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_avg_in     = out_avg_ff;
      out_all_in     = out_all_ff;
      out_recent_in  = out_recent_ff;
      out_frame_in   = out_frame_ff;
      div_req        = '0;
      ring_ctl       = '0;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               now_in   = req_bus.seconds_now;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (now_ff != last_seen_ff) begin
               // close the finished second: store its count and restart the ring sum
               recent_in        = frame_total_ff - at_last_ff;
               at_last_in       = frame_total_ff;
               last_seen_in     = now_ff;
               ring_ctl.write   = 1'b1;
               ring_ctl.slot    = slot_ff;
               ring_ctl.data    = frame_total_ff - at_last_ff;
               ring_ctl.sum_start = 1'b1;
               if (slot_ff == frwm_pkg::SlotWidth'(frwm_pkg::WindowSeconds - 1)) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
               state_in = ST_SUM_WAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SUM_WAIT: begin
            if (ring_sts.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = frwm_pkg::DivWidth'(ring_sum);
               div_req.divisor  = DW'(frwm_pkg::WindowSeconds);
               state_in         = ST_AVG_WAIT;
            end
         end
         ST_AVG_WAIT: begin
            if (div_sts.done) begin
               average_in = quotient[DW-1:0];
               // second zero: keep the overall rate as it stands
               if (now_ff != '0) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = frwm_pkg::DivWidth'(frame_total_ff);
                  div_req.divisor  = now_ff;
                  state_in         = ST_ALL_WAIT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ALL_WAIT: begin
            if (div_sts.done) begin
               overall_in = quotient[DW-1:0];
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               frame_total_in = frame_total_ff + 1'b1;
               rsp_valid_in   = 1'b1;
               out_avg_in     = average_ff;
               out_all_in     = overall_ff;
               out_recent_in  = recent_ff;
               out_frame_in   = frame_total_ff + 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      out_avg_ff    <= out_avg_in;
      out_all_ff    <= out_all_in;
      out_recent_ff <= out_recent_in;
      out_frame_ff  <= out_frame_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_total_ff <= '0;
         at_last_ff     <= '0;
         last_seen_ff   <= '0;
         recent_ff      <= '0;
         slot_ff        <= '0;
         average_ff     <= '0;
         overall_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_total_ff <= frame_total_in;
         at_last_ff     <= at_last_in;
         last_seen_ff   <= last_seen_in;
         recent_ff      <= recent_in;
         slot_ff        <= slot_in;
         average_ff     <= average_in;
         overall_ff     <= overall_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign req_bus.ready              = (state_ff == ST_IDLE);
   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.window_average     = out_avg_ff;
   assign rsp_bus.overall_rate       = out_all_ff;
   assign rsp_bus.last_second_frames = out_recent_ff;
   assign rsp_bus.frame_number       = out_frame_ff;

   a_one_request_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request accepted while another is in work");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= frwm_pkg::SlotWidth'(frwm_pkg::WindowSeconds - 1))
      else $error("ring slot beyond window");

   a_divider_free_on_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_ring_free_on_start: assert property (@(posedge clock) disable iff (reset)
      ring_ctl.sum_start |-> !ring_sts.busy)
      else $error("ring sum started while busy");

   a_frame_number_tracks_total: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> rsp_bus.frame_number == frame_total_ff)
      else $error("response frame number differs from frame total");

endmodule

/* bench/frame_rate_window_meter_tb.sv */
`timescale 1ns / 1ps

module frame_rate_window_meter_tb;

   typedef logic [frwm_pkg::DataWidth-1:0] word_type;

   typedef struct packed {
      word_type window_average;
      word_type overall_rate;
      word_type last_second_frames;
      word_type frame_number;
   } reading_type;

   localparam int StallLimit = 4000;
   localparam int HoldCycles = 400;

   // Tracks the meter state and queues the reading each accepted frame should give.
   class frame_rate_tracker;
      reading_type pending_readings[$];
      word_type    frame_total;
      word_type    frames_at_close;
      word_type    last_second;
      word_type    recent_count;
      word_type    average_now;
      word_type    overall_now;
      word_type    second_counts[frwm_pkg::WindowSeconds];
      int unsigned slot;
      int          mismatches;

      function new();
         frame_total     = '0;
         frames_at_close = '0;
         last_second     = '0;
         recent_count    = '0;
         average_now     = '0;
         overall_now     = '0;
         foreach (second_counts[k]) second_counts[k] = word_type'(frwm_pkg::FillCount);
         slot       = 0;
         mismatches = 0;
      endfunction

      function void note_frame(word_type secs);
         logic [63:0] sum;
         if (secs != last_second) begin
            last_second     = secs;
            recent_count    = frame_total - frames_at_close;
            frames_at_close = frame_total;
            if (slot >= frwm_pkg::WindowSeconds) slot = 0;
            second_counts[slot] = recent_count;
            slot = (slot + 1 >= frwm_pkg::WindowSeconds) ? 0 : slot + 1;
            sum = '0;
            foreach (second_counts[k]) sum += 64'(second_counts[k]);
            average_now = word_type'(sum / frwm_pkg::WindowSeconds);
            // second zero keeps the previous overall rate
            if (secs != '0) overall_now = frame_total / secs;
         end
         frame_total = frame_total + 1'b1;
         pending_readings.push_back('{average_now, overall_now, recent_count, frame_total});
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reading: avg %0d rate %0d last %0d frame %0d",
                        got.window_average, got.overall_rate, got.last_second_frames,
                        got.frame_number);
            return;
         end
         want = pending_readings.pop_front();
         if (got.window_average !== want.window_average ||
             got.overall_rate !== want.overall_rate ||
             got.last_second_frames !== want.last_second_frames ||
             got.frame_number !== want.frame_number) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("reading mismatch: expected avg %0d rate %0d last %0d frame %0d,",
                      want.window_average, want.overall_rate, want.last_second_frames,
                      want.frame_number);
               $display(" got avg %0d rate %0d last %0d frame %0d",
                        got.window_average, got.overall_rate,
                        got.last_second_frames, got.frame_number);
            end
         end
      endfunction

      function int pending();
         return pending_readings.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   frwm_req_if req_bus ();
   frwm_rsp_if rsp_bus ();

   frame_rate_window_meter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   frame_rate_tracker tracker;
   bit                quiet;
   bit                hold_request;
   int                hold_left;
   int                stall_cycles;
   word_type          cur_sec;
   int unsigned       frames_left;

   word_type directed_secs [23] = '{
      32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1, 32'd1, 32'd2, 32'd3, 32'd0, 32'd0,
      32'd5, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
      32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7
   };

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly runs of frames within one second, stepping the second; now and then a jump.
   function word_type pick_seconds();
      int unsigned r;
      if (frames_left > 0) begin
         frames_left--;
         return cur_sec;
      end
      r = $urandom_range(99);
      if (r < 75)      cur_sec = cur_sec + 1'b1;
      else if (r < 82) cur_sec = cur_sec + word_type'($urandom_range(2, 9));
      else if (r < 88) cur_sec = '0;
      else if (r < 94) cur_sec = word_type'($urandom);
      else             cur_sec = word_type'($urandom_range(1, 20));
      r = $urandom_range(99);
      if (r < 15)      frames_left = 0;
      else if (r < 90) frames_left = $urandom_range(1, 40);
      else             frames_left = $urandom_range(41, 150);
      return cur_sec;
   endfunction

   task automatic send_frame(input word_type secs);
      int unsigned gap;
      if (!quiet && $urandom_range(99) < 16) begin
         gap = ($urandom_range(99) < 10) ? $urandom_range(20, 120) : $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.seconds_now <= secs;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_frame(secs);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_reading('{rsp_bus.window_average, rsp_bus.overall_rate,
                                 rsp_bus.last_second_frames, rsp_bus.frame_number});
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (quiet) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= 16);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= StallLimit) begin
         $display("frame_rate_window_meter_tb: done, errors");
         $finish;
      end
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.seconds_now = '0;
      rsp_bus.ready       = 1'b0;
      quiet               = 1'b0;
      hold_request        = 1'b0;
      hold_left           = 0;
      stall_cycles        = 0;
      tracker             = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_secs[i]) send_frame(directed_secs[i]);

      cur_sec     = 32'd7;
      frames_left = 0;
      repeat (800) send_frame(pick_seconds());

      // hold off until the meter has drained
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);

      // stall the response side while requests keep coming, no idling otherwise
      quiet        = 1'b1;
      hold_request = 1'b1;
      repeat (180) send_frame(pick_seconds());
      quiet = 1'b0;

      repeat (1000) send_frame(pick_seconds());

      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("frame_rate_window_meter_tb: done, clean");
      else
         $display("frame_rate_window_meter_tb: done, errors");
      $finish;
   end

endmodule
